/* hw/rtl/wcmp_port_select_defines.svh */
// assertion macros used by the wcmp port select rtl
`ifndef WCMP_PORT_SELECT_DEFINES_SVH
`define WCMP_PORT_SELECT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WCMP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define WCMP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wcmp_ps_pkg.sv */
// types, constants and helpers for the wcmp port select block
package wcmp_ps_pkg;

    localparam int HASH_W       = 32;
    localparam int DIV_CNT_W    = $clog2(HASH_W);
    localparam int INDEX_W      = 4;
    localparam int WEIGHT_IN_W  = 16;
    localparam int PORT_IN_W    = 8;
    localparam int COUNT_IN_W   = 5;
    localparam int STAGE_W      = 2;
    localparam int PORT_OUT_W   = 8;
    localparam int ROT_W        = $clog2(HASH_W);

    localparam logic [ROT_W-1:0] ROT_NONE  = ROT_W'(0);
    localparam logic [ROT_W-1:0] ROT_S2_UP = ROT_W'(4);
    localparam logic [ROT_W-1:0] ROT_S2_DN = ROT_W'(16);
    localparam logic [ROT_W-1:0] ROT_S3_UP = ROT_W'(8);
    localparam logic [ROT_W-1:0] ROT_S3_DN = ROT_W'(12);

    localparam logic [STAGE_W-1:0] STAGE_ONE   = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_TWO   = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_THREE = 2'd3;

    typedef enum logic {
        ACTION_LOAD   = 1'b0,
        ACTION_SELECT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SUM_ZERO  = 2'd1,
        STATUS_BAD_STAGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MOD,
        ST_WALK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        action_t                 action;
        logic [INDEX_W-1:0]      entry_index;
        logic [WEIGHT_IN_W-1:0]  entry_weight;
        logic [PORT_IN_W-1:0]    entry_port;
        logic [HASH_W-1:0]       flow_hash;
        logic [STAGE_W-1:0]      stage;
        logic                    uplink;
        logic [COUNT_IN_W-1:0]   option_count;
    } in_item_t;

    typedef struct packed {
        logic [PORT_OUT_W-1:0] out_port;
        status_t               status;
    } out_item_t;

    function automatic logic stage_ok(input logic [STAGE_W-1:0] stage);
        return (stage == STAGE_ONE) || (stage == STAGE_TWO) || (stage == STAGE_THREE);
    endfunction

    function automatic logic [ROT_W-1:0] rot_amount(input logic [STAGE_W-1:0] stage,
                                                    input logic uplink);
        logic [ROT_W-1:0] amt;
        unique case (stage)
            STAGE_TWO:   amt = uplink ? ROT_S2_UP : ROT_S2_DN;
            STAGE_THREE: amt = uplink ? ROT_S3_UP : ROT_S3_DN;
            default:     amt = ROT_NONE;
        endcase
        return amt;
    endfunction

    function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] val,
                                               input logic [ROT_W-1:0] amt);
        logic [2*HASH_W-1:0] dbl;
        dbl = {val, val} << amt;
        return dbl[2*HASH_W-1:HASH_W];
    endfunction

endpackage

/* hw/rtl/wcmp_port_select.sv */
// top level of the weighted multipath port selector
//
// s_ channel takes items: a load item writes one option entry (weight, port)
// into the table and gives no result; a select item gives exactly one result
// on the m_ channel (out_port, status).
// one item is worked at a time: s_ready is high only while the control is idle.
// a select item first sums the weights of its count options through the table
// read port, then runs the bit-serial remainder unit (32 steps and a done
// strobe), then walks the table, and last hands the result to the output
// register.
// a bad stage or a zero count skips the table and goes straight to the
// result; a zero weight sum read from the table skips the remainder unit
// and the walk.
// the result sits in an output register; the next item is accepted while it
// waits, and a further select result waits in the control until m_ready.
// reset clears the control and the output valid; table contents stay
// undefined until written, and a select over an unloaded entry is not allowed.
// stalling m_ready never drops or repeats a result.
`include "wcmp_port_select_defines.svh"

module wcmp_port_select #(
    parameter int MAX_OPTIONS = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int PORT_BITS   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  wcmp_ps_pkg::in_item_t  s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output wcmp_ps_pkg::out_item_t m_item
);

    localparam int IDX_W = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_OPTIONS + 1);
    localparam int SUM_W = WEIGHT_BITS + CNT_W;

    wcmp_ps_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [wcmp_ps_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SUM_W-1:0]       rem_reg, rem_next;
    wcmp_ps_pkg::out_item_t res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    wcmp_ps_pkg::out_item_t m_item_reg, m_item_next;

    logic                   accept;
    logic                   wr_en;
    logic                   rd_en;
    logic [WEIGHT_BITS-1:0] rd_weight;
    logic [PORT_BITS-1:0]   rd_port;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       div_rem;
    logic [CNT_W-1:0]       sel_count;

    assign accept = s_valid && s_ready;
    assign wr_en  = accept && (s_item.action == wcmp_ps_pkg::ACTION_LOAD)
                    && (int'(s_item.entry_index) < MAX_OPTIONS);
    assign sel_count = (int'(s_item.option_count) > MAX_OPTIONS) ?
                       CNT_W'(MAX_OPTIONS) : CNT_W'(s_item.option_count);

    wcmp_ps_table #(
        .MAX_OPTIONS (MAX_OPTIONS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .PORT_BITS   (PORT_BITS),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (IDX_W'(s_item.entry_index)),
        .wr_weight (WEIGHT_BITS'(s_item.entry_weight)),
        .wr_port   (PORT_BITS'(s_item.entry_port)),
        .rd_en     (rd_en),
        .rd_addr   (issue_reg[IDX_W-1:0]),
        .rd_weight (rd_weight),
        .rd_port   (rd_port)
    );

    wcmp_ps_mod #(
        .SUM_W (SUM_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (hash_reg),
        .divisor   (sum_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wcmp_ps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        issue_next = issue_reg;
        pend_next  = 1'b0;
        count_next = count_reg;
        hash_next  = hash_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        s_ready    = 1'b0;
        rd_en      = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            wcmp_ps_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_item.action == wcmp_ps_pkg::ACTION_SELECT)) begin
                    issue_next = '0;
                    count_next = sel_count;
                    hash_next  = wcmp_ps_pkg::rotl(s_item.flow_hash,
                                     wcmp_ps_pkg::rot_amount(s_item.stage, s_item.uplink));
                    sum_next   = '0;
                    res_next.out_port = '0;
                    if (!wcmp_ps_pkg::stage_ok(s_item.stage)) begin
                        res_next.status = wcmp_ps_pkg::STATUS_BAD_STAGE;
                        state_next      = wcmp_ps_pkg::ST_RESULT;
                    end else if (sel_count == '0) begin
                        res_next.status = wcmp_ps_pkg::STATUS_SUM_ZERO;
                        state_next      = wcmp_ps_pkg::ST_RESULT;
                    end else begin
                        res_next.status = wcmp_ps_pkg::STATUS_OK;
                        state_next      = wcmp_ps_pkg::ST_SUM;
                    end
                end
            end
            wcmp_ps_pkg::ST_SUM: begin
                rd_en      = issue_reg < count_reg;
                pend_next  = rd_en;
                issue_next = rd_en ? issue_reg + 1'b1 : issue_reg;
                if (pend_reg) begin
                    sum_next = sum_reg + SUM_W'(rd_weight);
                end
                if (!rd_en && !pend_reg) begin
                    if (sum_reg == '0) begin
                        res_next.status = wcmp_ps_pkg::STATUS_SUM_ZERO;
                        state_next      = wcmp_ps_pkg::ST_RESULT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = wcmp_ps_pkg::ST_MOD;
                    end
                end
            end
            wcmp_ps_pkg::ST_MOD: begin
                issue_next = '0;
                if (div_done) begin
                    rem_next   = div_rem;
                    state_next = wcmp_ps_pkg::ST_WALK;
                end
            end
            wcmp_ps_pkg::ST_WALK: begin
                rd_en      = issue_reg < count_reg;
                pend_next  = rd_en;
                issue_next = rd_en ? issue_reg + 1'b1 : issue_reg;
                if (pend_reg) begin
                    if (rem_reg < SUM_W'(rd_weight)) begin
                        res_next.out_port = wcmp_ps_pkg::PORT_OUT_W'(rd_port);
                        state_next        = wcmp_ps_pkg::ST_RESULT;
                    end else begin
                        rem_next = rem_reg - SUM_W'(rd_weight);
                    end
                end else if (!rd_en) begin
                    state_next = wcmp_ps_pkg::ST_RESULT;
                end
            end
            wcmp_ps_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = wcmp_ps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wcmp_ps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        if ((state_reg == wcmp_ps_pkg::ST_RESULT) && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
            m_item_next  = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg  <= issue_next;
        count_reg  <= count_next;
        hash_reg   <= hash_next;
        sum_reg    <= sum_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `WCMP_ASSERT_NEXT(a_select_leaves_idle, aclk, aresetn,
        accept && (s_item.action == wcmp_ps_pkg::ACTION_SELECT),
        state_reg != wcmp_ps_pkg::ST_IDLE, "select item did not start work")
    `WCMP_ASSERT_SAME(a_div_nonzero, aclk, aresetn,
        div_start, sum_reg != '0, "remainder unit started with zero weight sum")
    `WCMP_ASSERT_SAME(a_walk_rem_bound, aclk, aresetn,
        state_reg == wcmp_ps_pkg::ST_WALK, rem_reg < sum_reg,
        "walk remainder not below weight sum")
    `WCMP_ASSERT_SAME(a_fault_port_zero, aclk, aresetn,
        m_valid_reg && (m_item_reg.status != wcmp_ps_pkg::STATUS_OK),
        m_item_reg.out_port == '0, "faulted result carries a port")
    `WCMP_ASSERT_SAME(a_no_read_idle, aclk, aresetn,
        state_reg == wcmp_ps_pkg::ST_IDLE, !rd_en && !div_start,
        "table read or divide started while idle")

endmodule

/* hw/rtl/wcmp_ps_table.sv */
// option table memory: weight and port per entry, registered read
module wcmp_ps_table #(
    parameter int MAX_OPTIONS = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int PORT_BITS   = 8,
    parameter int IDX_W       = 4
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [WEIGHT_BITS-1:0] wr_weight,
    input  logic [PORT_BITS-1:0]   wr_port,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [WEIGHT_BITS-1:0] rd_weight,
    output logic [PORT_BITS-1:0]   rd_port
);

    logic [WEIGHT_BITS+PORT_BITS-1:0] mem [MAX_OPTIONS];
    logic [WEIGHT_BITS+PORT_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_weight, wr_port};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_weight = rd_data_reg[WEIGHT_BITS+PORT_BITS-1:PORT_BITS];
    assign rd_port   = rd_data_reg[PORT_BITS-1:0];

endmodule

/* hw/rtl/wcmp_ps_mod.sv */
// restoring remainder unit: hash modulo weight sum, one quotient bit per cycle
module wcmp_ps_mod #(
    parameter int SUM_W = 21
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [wcmp_ps_pkg::HASH_W-1:0] dividend,
    input  logic [SUM_W-1:0]               divisor,
    output logic                           done,
    output logic [SUM_W-1:0]               remainder
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [wcmp_ps_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [wcmp_ps_pkg::HASH_W-1:0]    dvd_reg, dvd_next;
    logic [SUM_W-1:0]                  dsr_reg, dsr_next;
    logic [SUM_W-1:0]                  rem_reg, rem_next;
    logic [SUM_W:0]                    trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[wcmp_ps_pkg::HASH_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = SUM_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = SUM_W'(trial);
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == wcmp_ps_pkg::DIV_CNT_W'(wcmp_ps_pkg::HASH_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* sim/wcmp_port_select_test.sv */
// self-checking testbench for the wcmp port selector: table loads and weighted port selects
module wcmp_port_select_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam logic [1:0] STAGE_UNKNOWN = 2'd0;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    wcmp_ps_pkg::in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    wcmp_ps_pkg::out_item_t m_item;

    wcmp_ps_pkg::in_item_t  queued_requests[$];
    wcmp_ps_pkg::out_item_t expected_choices[$];

    logic [15:0] weight_copy[TABLE_DEPTH];
    logic [7:0]  port_copy[TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] written_mask = '0;

    int accepted_count = 0;
    int mismatch_count = 0;
    int load_count = 0;
    int ok_count = 0;
    int sum_zero_count = 0;
    int bad_stage_count = 0;

    wcmp_port_select uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic bit calm_window();
        return accepted_count >= 400 && accepted_count < 520;
    endfunction

    function automatic void predict_choice(input wcmp_ps_pkg::in_item_t it);
        int unsigned count;
        logic [31:0] hash;
        logic [4:0]  rot;
        logic [63:0] total_weight;
        logic [63:0] remainder;
        wcmp_ps_pkg::out_item_t res;
        if (it.action == wcmp_ps_pkg::ACTION_LOAD) begin
            weight_copy[it.entry_index] = it.entry_weight;
            port_copy[it.entry_index] = it.entry_port;
            load_count++;
            return;
        end
        count = (it.option_count > TABLE_DEPTH) ? TABLE_DEPTH : it.option_count;
        res.out_port = '0;
        res.status = wcmp_ps_pkg::STATUS_OK;
        case (it.stage)
            wcmp_ps_pkg::STAGE_ONE: rot = 5'(wcmp_ps_pkg::ROT_NONE);
            wcmp_ps_pkg::STAGE_TWO:
                rot = it.uplink ? 5'(wcmp_ps_pkg::ROT_S2_UP) : 5'(wcmp_ps_pkg::ROT_S2_DN);
            wcmp_ps_pkg::STAGE_THREE:
                rot = it.uplink ? 5'(wcmp_ps_pkg::ROT_S3_UP) : 5'(wcmp_ps_pkg::ROT_S3_DN);
            default: begin
                rot = '0;
                res.status = wcmp_ps_pkg::STATUS_BAD_STAGE;
            end
        endcase
        if (res.status == wcmp_ps_pkg::STATUS_OK) begin
            total_weight = '0;
            for (int i = 0; i < count; i++)
                total_weight += weight_copy[i];
            if (total_weight == 0) begin
                res.status = wcmp_ps_pkg::STATUS_SUM_ZERO;
            end else begin
                hash = it.flow_hash;
                if (rot != 0)
                    hash = (hash << rot) | (hash >> (32 - rot));
                remainder = {32'd0, hash} % total_weight;
                for (int i = 0; i < count; i++) begin
                    if (remainder < weight_copy[i]) begin
                        res.out_port = port_copy[i];
                        break;
                    end
                    remainder -= weight_copy[i];
                end
            end
        end
        expected_choices.push_back(res);
    endfunction

    function automatic wcmp_ps_pkg::in_item_t noise_item();
        wcmp_ps_pkg::in_item_t r;
        r.action = wcmp_ps_pkg::action_t'($urandom_range(1));
        r.entry_index = 4'($urandom);
        r.entry_weight = 16'($urandom);
        r.entry_port = 8'($urandom);
        r.flow_hash = $urandom;
        r.stage = 2'($urandom);
        r.uplink = 1'($urandom);
        r.option_count = 5'($urandom);
        return r;
    endfunction

    function automatic void push_load(input int idx, input int weight, input int port);
        wcmp_ps_pkg::in_item_t r;
        r = noise_item();
        r.action = wcmp_ps_pkg::ACTION_LOAD;
        r.entry_index = 4'(idx);
        r.entry_weight = 16'(weight);
        r.entry_port = 8'(port);
        written_mask[idx] = 1'b1;
        queued_requests.push_back(r);
    endfunction

    // leading run of written entries bounds the count of any select that reads the table
    function automatic void push_select(input logic [31:0] hash, input logic [1:0] stage,
                                        input logic up, input int count);
        wcmp_ps_pkg::in_item_t r;
        int safe;
        int used;
        safe = 0;
        while (safe < TABLE_DEPTH && written_mask[safe])
            safe++;
        used = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        if (wcmp_ps_pkg::stage_ok(stage) && used > safe)
            count = safe;
        r = noise_item();
        r.action = wcmp_ps_pkg::ACTION_SELECT;
        r.flow_hash = hash;
        r.stage = stage;
        r.uplink = up;
        r.option_count = 5'(count);
        queued_requests.push_back(r);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_choice(s_item);
                accepted_count++;
            end
            if (queued_requests.size() != 0 && (calm_window() || $urandom_range(99) >= 26)) begin
                s_valid <= 1'b1;
                s_item <= queued_requests.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        wcmp_ps_pkg::out_item_t exp_item;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_choices.size() == 0) begin
                    $error("unexpected result item: out_port %0d, status %0d",
                           m_item.out_port, m_item.status);
                    mismatch_count++;
                end else begin
                    exp_item = expected_choices.pop_front();
                    if (m_item.out_port !== exp_item.out_port) begin
                        $error("out_port: expected %0d, actual %0d",
                               exp_item.out_port, m_item.out_port);
                        mismatch_count++;
                    end
                    if (m_item.status !== exp_item.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_item.status, m_item.status);
                        mismatch_count++;
                    end
                    case (exp_item.status)
                        wcmp_ps_pkg::STATUS_OK:       ok_count++;
                        wcmp_ps_pkg::STATUS_SUM_ZERO: sum_zero_count++;
                        default:                      bad_stage_count++;
                    endcase
                end
            end
            m_ready <= calm_window() || ($urandom_range(99) >= 26);
        end
    end

    initial begin
        int w;
        int c;
        // zero weight entry in front, extremes of weight and port
        push_load(0, 0, 8'hFF);
        push_load(1, 16'hFFFF, 0);
        push_load(2, 1, 8'hA5);
        push_load(3, 16'h8000, 8'h5A);
        push_select(32'hFFFF_FFFF, STAGE_UNKNOWN, 1'b1, 31);
        push_select(32'h1234_5678, wcmp_ps_pkg::STAGE_ONE, 1'b0, 0);
        push_select(32'h1234_5678, wcmp_ps_pkg::STAGE_ONE, 1'b1, 1);
        push_select(32'h0000_0000, wcmp_ps_pkg::STAGE_ONE, 1'b0, 4);
        push_select(32'h1234_5678, wcmp_ps_pkg::STAGE_TWO, 1'b1, 4);
        push_select(32'h1234_5678, wcmp_ps_pkg::STAGE_TWO, 1'b0, 4);
        push_select(32'h1234_5678, wcmp_ps_pkg::STAGE_THREE, 1'b1, 4);
        push_select(32'h1234_5678, wcmp_ps_pkg::STAGE_THREE, 1'b0, 4);
        push_select(32'hFFFF_FFFF, wcmp_ps_pkg::STAGE_ONE, 1'b0, 2);
        for (int i = 4; i < TABLE_DEPTH; i++)
            push_load(i, (i == 7) ? 0 : ((i == 15) ? 16'hFFFF : i * 3), i * 17);
        push_select(32'hDEAD_BEEF, wcmp_ps_pkg::STAGE_THREE, 1'b0, 16);
        push_select(32'hCAFE_F00D, wcmp_ps_pkg::STAGE_TWO, 1'b1, 31);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99) < 25) begin
                case ($urandom_range(9))
                    0:       w = 0;
                    1, 2, 3: w = $urandom_range(15);
                    4, 5:    w = $urandom_range(255);
                    default: w = $urandom_range(16'hFFFF);
                endcase
                push_load($urandom_range(TABLE_DEPTH - 1), w, $urandom_range(255));
            end else begin
                c = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
                push_select($urandom,
                            ($urandom_range(9) == 0) ? STAGE_UNKNOWN : 2'($urandom_range(1, 3)),
                            1'($urandom), c);
            end
        end

        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_requests.size() != 0 || s_valid || expected_choices.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (expected_choices.size() != 0) begin
            $error("%0d expected result items never arrived", expected_choices.size());
            mismatch_count++;
        end
        $display("%0d items accepted, %0d of them table loads", accepted_count, load_count);
        $display("results checked: %0d selected, %0d zero weight sum, %0d bad stage",
                 ok_count, sum_zero_count, bad_stage_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d items still queued", queued_requests.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/wcmp_ps_pkg.sv
hw/rtl/wcmp_ps_table.sv
hw/rtl/wcmp_ps_mod.sv
hw/rtl/wcmp_port_select.sv
sim/wcmp_port_select_test.sv
